// File: rtl/core/mqttph_pkg.sv
package mqttph_pkg;

    localparam int MAX_LENGTH_BYTES = 4;

    // parser phase, one-hot
    typedef enum logic [11:0] {
        PH_TYPE    = 12'b0000_0000_0001,
        PH_LEN     = 12'b0000_0000_0010,
        PH_ACKF    = 12'b0000_0000_0100,
        PH_RC      = 12'b0000_0000_1000,
        PH_IDH     = 12'b0000_0001_0000,
        PH_IDL     = 12'b0000_0010_0000,
        PH_TLH     = 12'b0000_0100_0000,
        PH_TLL     = 12'b0000_1000_0000,
        PH_TOPIC   = 12'b0001_0000_0000,
        PH_PAYLOAD = 12'b0010_0000_0000,
        PH_REASON  = 12'b0100_0000_0000,
        PH_DISCARD = 12'b1000_0000_0000
    } phase_t;

    localparam logic [3:0] ROLE_TYPE    = 4'd0;
    localparam logic [3:0] ROLE_LEN     = 4'd1;
    localparam logic [3:0] ROLE_ACKF    = 4'd2;
    localparam logic [3:0] ROLE_RC      = 4'd3;
    localparam logic [3:0] ROLE_IDH     = 4'd4;
    localparam logic [3:0] ROLE_IDL     = 4'd5;
    localparam logic [3:0] ROLE_TLH     = 4'd6;
    localparam logic [3:0] ROLE_TLL     = 4'd7;
    localparam logic [3:0] ROLE_TOPIC   = 4'd8;
    localparam logic [3:0] ROLE_PAYLOAD = 4'd9;
    localparam logic [3:0] ROLE_REASON  = 4'd10;
    localparam logic [3:0] ROLE_DISCARD = 4'd11;

    localparam logic [3:0] PT_CONNACK     = 4'd2;
    localparam logic [3:0] PT_PUBLISH     = 4'd3;
    localparam logic [3:0] PT_PUBACK      = 4'd4;
    localparam logic [3:0] PT_SUBSCRIBE   = 4'd8;
    localparam logic [3:0] PT_SUBACK      = 4'd9;
    localparam logic [3:0] PT_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] PT_UNSUBACK    = 4'd11;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  type_byte;
        logic [27:0] len_acc;
        logic [2:0]  len_cnt;
        logic [27:0] bytes_left;
        logic [15:0] topic_len;
        logic [15:0] topic_left;
        logic [15:0] id;
        logic        err;
        logic        id_valid;
        logic        tlen_valid;
        logic        plen_valid;
        logic [27:0] plen;
    } state_t;

    typedef struct packed {
        logic [3:0]  byte_role;
        logic [3:0]  packet_type;
        logic [3:0]  header_flags;
        logic [1:0]  qos_level;
        logic        dup_flag;
        logic        retain_flag;
        logic [27:0] remaining_length;
        logic [15:0] packet_id;
        logic [15:0] topic_length;
        logic [27:0] payload_length;
        logic        packet_end;
        logic        malformed;
    } result_t;

endpackage

// File: rtl/core/mqttph_step.sv
module mqttph_step (
    input  mqttph_pkg::state_t  cur,
    input  logic [7:0]          data_byte,
    output mqttph_pkg::state_t  nxt,
    output mqttph_pkg::result_t res
);

    logic [3:0]  role;
    logic        pend;
    logic [3:0]  kind;
    logic        qos_nz;
    logic [27:0] len_add;
    logic [15:0] tl;
    logic [17:0] need;
    logic        pub;

    always_comb begin
        nxt    = cur;
        role   = mqttph_pkg::ROLE_DISCARD;
        pend   = 1'b0;
        kind   = cur.type_byte[7:4];
        qos_nz = (cur.type_byte[2:1] != 2'd0);
        tl     = {cur.topic_len[15:8], data_byte};
        need   = 18'd2 + {2'b00, tl} + (qos_nz ? 18'd2 : 18'd0);
        case (cur.len_cnt[1:0])
            2'd0: len_add = {21'b0, data_byte[6:0]};
            2'd1: len_add = {14'b0, data_byte[6:0], 7'b0};
            2'd2: len_add = {7'b0, data_byte[6:0], 14'b0};
            2'd3: len_add = {data_byte[6:0], 21'b0};
            default: len_add = 28'd0;
        endcase

        if (cur.err) begin
            role = mqttph_pkg::ROLE_DISCARD;
        end else begin
            case (cur.phase)
                mqttph_pkg::PH_TYPE: begin
                    role           = mqttph_pkg::ROLE_TYPE;
                    nxt.type_byte  = data_byte;
                    nxt.len_acc    = 28'd0;
                    nxt.len_cnt    = 3'd0;
                    nxt.bytes_left = 28'd0;
                    nxt.topic_len  = 16'd0;
                    nxt.topic_left = 16'd0;
                    nxt.id         = 16'd0;
                    nxt.id_valid   = 1'b0;
                    nxt.tlen_valid = 1'b0;
                    nxt.plen_valid = 1'b0;
                    nxt.plen       = 28'd0;
                    nxt.phase      = mqttph_pkg::PH_LEN;
                end
                mqttph_pkg::PH_LEN: begin
                    role        = mqttph_pkg::ROLE_LEN;
                    nxt.len_acc = cur.len_acc + len_add;
                    nxt.len_cnt = cur.len_cnt + 3'd1;
                    if (data_byte[7]) begin
                        if (nxt.len_cnt >= 3'(mqttph_pkg::MAX_LENGTH_BYTES)) begin
                            nxt.err = 1'b1;
                        end
                    end else begin
                        nxt.bytes_left = nxt.len_acc;
                        // types 2..11 carry at least a two-byte variable header
                        if (kind >= mqttph_pkg::PT_CONNACK && kind <= mqttph_pkg::PT_UNSUBACK
                                && nxt.len_acc < 28'd2) begin
                            nxt.err = 1'b1;
                        end else begin
                            if (kind >= mqttph_pkg::PT_SUBSCRIBE
                                    && kind <= mqttph_pkg::PT_UNSUBACK) begin
                                nxt.plen       = nxt.len_acc - 28'd2;
                                nxt.plen_valid = 1'b1;
                            end
                            if (nxt.len_acc == 28'd0) begin
                                pend      = 1'b1;
                                nxt.phase = mqttph_pkg::PH_TYPE;
                            end else if (kind == mqttph_pkg::PT_CONNACK) begin
                                nxt.phase = mqttph_pkg::PH_ACKF;
                            end else if (kind == mqttph_pkg::PT_PUBLISH) begin
                                nxt.phase = mqttph_pkg::PH_TLH;
                            end else if (kind >= mqttph_pkg::PT_PUBACK
                                    && kind <= mqttph_pkg::PT_UNSUBACK) begin
                                nxt.phase = mqttph_pkg::PH_IDH;
                            end else begin
                                nxt.phase = mqttph_pkg::PH_DISCARD;
                            end
                        end
                    end
                end
                default: begin
                    nxt.bytes_left = cur.bytes_left - 28'd1;
                    case (cur.phase)
                        mqttph_pkg::PH_ACKF: begin
                            role      = mqttph_pkg::ROLE_ACKF;
                            nxt.phase = mqttph_pkg::PH_RC;
                        end
                        mqttph_pkg::PH_RC: begin
                            role      = mqttph_pkg::ROLE_RC;
                            nxt.phase = mqttph_pkg::PH_DISCARD;
                        end
                        mqttph_pkg::PH_IDH: begin
                            role      = mqttph_pkg::ROLE_IDH;
                            nxt.id    = {data_byte, 8'h00};
                            nxt.phase = mqttph_pkg::PH_IDL;
                        end
                        mqttph_pkg::PH_IDL: begin
                            role         = mqttph_pkg::ROLE_IDL;
                            nxt.id       = {cur.id[15:8], data_byte};
                            nxt.id_valid = 1'b1;
                            if (kind == mqttph_pkg::PT_PUBLISH || kind == mqttph_pkg::PT_SUBSCRIBE
                                    || kind == mqttph_pkg::PT_UNSUBSCRIBE) begin
                                nxt.phase = mqttph_pkg::PH_PAYLOAD;
                            end else if (kind == mqttph_pkg::PT_SUBACK
                                    || kind == mqttph_pkg::PT_UNSUBACK) begin
                                nxt.phase = mqttph_pkg::PH_REASON;
                            end else begin
                                nxt.phase = mqttph_pkg::PH_DISCARD;
                            end
                        end
                        mqttph_pkg::PH_TLH: begin
                            role          = mqttph_pkg::ROLE_TLH;
                            nxt.topic_len = {data_byte, 8'h00};
                            nxt.phase     = mqttph_pkg::PH_TLL;
                        end
                        mqttph_pkg::PH_TLL: begin
                            role           = mqttph_pkg::ROLE_TLL;
                            nxt.topic_len  = tl;
                            nxt.tlen_valid = 1'b1;
                            // topic plus header must fit in the remaining length
                            if ({10'b0, need} > cur.len_acc) begin
                                nxt.err = 1'b1;
                            end else begin
                                nxt.plen       = cur.len_acc - {10'b0, need};
                                nxt.plen_valid = 1'b1;
                                nxt.topic_left = tl;
                                if (tl != 16'd0) begin
                                    nxt.phase = mqttph_pkg::PH_TOPIC;
                                end else if (qos_nz) begin
                                    nxt.phase = mqttph_pkg::PH_IDH;
                                end else begin
                                    nxt.phase = mqttph_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                        mqttph_pkg::PH_TOPIC: begin
                            role           = mqttph_pkg::ROLE_TOPIC;
                            nxt.topic_left = cur.topic_left - 16'd1;
                            if (nxt.topic_left == 16'd0) begin
                                nxt.phase = qos_nz ? mqttph_pkg::PH_IDH
                                                   : mqttph_pkg::PH_PAYLOAD;
                            end
                        end
                        mqttph_pkg::PH_PAYLOAD: begin
                            role = mqttph_pkg::ROLE_PAYLOAD;
                        end
                        mqttph_pkg::PH_REASON: begin
                            role = mqttph_pkg::ROLE_REASON;
                        end
                        default: begin
                            role      = mqttph_pkg::ROLE_DISCARD;
                            nxt.phase = mqttph_pkg::PH_DISCARD;
                        end
                    endcase
                    if (!nxt.err && nxt.bytes_left == 28'd0) begin
                        pend      = 1'b1;
                        nxt.phase = mqttph_pkg::PH_TYPE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        pub                  = (nxt.type_byte[7:4] == mqttph_pkg::PT_PUBLISH);
        res.byte_role        = role;
        res.packet_type      = nxt.type_byte[7:4];
        res.header_flags     = nxt.type_byte[3:0];
        res.qos_level        = pub ? nxt.type_byte[2:1] : 2'd0;
        res.dup_flag         = pub ? nxt.type_byte[3] : 1'b0;
        res.retain_flag      = pub ? nxt.type_byte[0] : 1'b0;
        res.remaining_length = nxt.len_acc;
        res.packet_id        = nxt.id_valid ? nxt.id : 16'd0;
        res.topic_length     = nxt.tlen_valid ? nxt.topic_len : 16'd0;
        res.payload_length   = nxt.plen_valid ? nxt.plen : 28'd0;
        res.packet_end       = pend && !nxt.err;
        res.malformed        = nxt.err;
    end

endmodule

// File: rtl/core/mqtt_packet_header_parser.sv
// MQTT 3.1.1 control packet parser for a byte stream of back-to-back packets.
// Input channel s_*: one stream byte per item (s_data_byte), valid/ready.
// Output channel m_*: one result per input byte, carrying the role of that
// byte in its packet, the decoded type and flags, remaining length, packet id,
// PUBLISH topic and payload lengths, a last-byte-of-packet strobe and a
// sticky malformed flag.
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while not stalled; parser state and the result
// are both updated by a single combinational step from the accepted byte.
// Stall: the result register holds while m_ready is low; a new byte is taken
// in the same cycle the held result is taken, so a stalled receiver stops
// the input only while the result register is full and not being drained.
// Reset (aresetn low, synchronous): the parser waits for a type byte, all decoded
// state fields and the error flag are cleared and the output is empty.
// Once malformed is set, every later byte is discarded until reset.
module mqtt_packet_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_byte_role,
    output logic [3:0]  m_packet_type,
    output logic [3:0]  m_header_flags,
    output logic [1:0]  m_qos_level,
    output logic        m_dup_flag,
    output logic        m_retain_flag,
    output logic [27:0] m_remaining_length,
    output logic [15:0] m_packet_id,
    output logic [15:0] m_topic_length,
    output logic [27:0] m_payload_length,
    output logic        m_packet_end,
    output logic        m_malformed
);

    mqttph_pkg::state_t  state_reg;
    mqttph_pkg::state_t  state_next;
    mqttph_pkg::result_t res_reg;
    mqttph_pkg::result_t res_next;
    logic                m_valid_reg;
    logic                s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    mqttph_step u_step (
        .cur       (state_reg),
        .data_byte (s_data_byte),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{phase: mqttph_pkg::PH_TYPE, default: '0};
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_byte_role        = res_reg.byte_role;
    assign m_packet_type      = res_reg.packet_type;
    assign m_header_flags     = res_reg.header_flags;
    assign m_qos_level        = res_reg.qos_level;
    assign m_dup_flag         = res_reg.dup_flag;
    assign m_retain_flag      = res_reg.retain_flag;
    assign m_remaining_length = res_reg.remaining_length;
    assign m_packet_id        = res_reg.packet_id;
    assign m_topic_length     = res_reg.topic_length;
    assign m_payload_length   = res_reg.payload_length;
    assign m_packet_end       = res_reg.packet_end;
    assign m_malformed        = res_reg.malformed;

    // error is sticky across items
    a_malformed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_malformed) |=> (!m_valid || m_malformed))
        else $error("malformed flag dropped without reset");

    a_end_not_malformed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_packet_end && m_malformed))
        else $error("packet end flagged on malformed stream");

    // an error can only be raised on a length byte or the topic length low byte
    a_malformed_role: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_malformed) |->
            (m_byte_role == mqttph_pkg::ROLE_LEN || m_byte_role == mqttph_pkg::ROLE_TLL
             || m_byte_role == mqttph_pkg::ROLE_DISCARD))
        else $error("malformed item with unexpected byte role");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted item produced no result");

endmodule
